FILE: rtl/core/prq_pkg.sv
// Package for the priority run-queue scheduler.
// Holds the request and status codes and the fixed field widths.
// No dependencies.
`default_nettype none

package prq_pkg;

  // Fixed widths of the words on the request and result channels.
  localparam int FUNC_W   = 2;
  localparam int PROC_W   = 4;
  localparam int PRIO_W   = 3;
  localparam int STATUS_W = 2;

  // Request codes.
  localparam logic [FUNC_W-1:0] FUNC_ENQ_TAIL = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ENQ_HEAD = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEQUEUE  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOP      = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BLOCKED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_QUEUED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

endpackage

`default_nettype wire

FILE: rtl/core/prq_req_if.sv
// Request channel of the priority run-queue scheduler.
// Valid/ready handshake carrying one request word; widths from prq_pkg.
`default_nettype none

interface prq_req_if;
  logic                          valid;
  logic                          ready;
  logic [prq_pkg::FUNC_W-1:0]    func;
  logic [prq_pkg::PROC_W-1:0]    proc_id;
  logic [prq_pkg::PRIO_W-1:0]    priority_req;
  logic                          blocked;

  modport source (output valid, func, proc_id, priority_req, blocked, input ready);
  modport sink   (input valid, func, proc_id, priority_req, blocked, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/prq_rsp_if.sv
// Result channel of the priority run-queue scheduler.
// Valid/ready handshake carrying one result word; widths from prq_pkg.
`default_nettype none

interface prq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [prq_pkg::STATUS_W-1:0]  status;
  logic [prq_pkg::PROC_W-1:0]    chosen_proc;
  logic [prq_pkg::PRIO_W-1:0]    chosen_priority;

  modport source (output valid, status, chosen_proc, chosen_priority, input ready);
  modport sink   (input valid, status, chosen_proc, chosen_priority, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/priority_run_queue_core.sv
// Top level of the priority run-queue scheduler.
// Depends on prq_pkg, prq_req_if, prq_rsp_if and prq_pick.
//
// Usage:
//   Requests enter on in_chan, a valid/ready channel. Each request word
//   either appends a process to the tail of its level's FIFO, pushes it
//   at the head, dequeues the head of the lowest-numbered non-empty
//   level, or does nothing (NOP). Exactly one result word per request
//   leaves on out_chan. A request is taken into an input register;
//   the lookup, priority encode and list update then run in one pass
//   and the result is loaded into the output register once that
//   register is free. While the receiver takes results, a new request
//   is taken every cycle: one word per clock sustained throughput.
//   The one-pass list update (head/tail/link tables and the level
//   encoder) sets that rate. When the receiver stalls, the output
//   register holds its word and the input register holds the next one;
//   in_chan.ready falls only when both are full.
//   Reset (rst_n low, synchronous) empties every level and marks every
//   process as not queued; no clearing pass is needed.
`default_nettype none

module priority_run_queue_core #(
  parameter int PROC_COUNT  = 16,
  parameter int PRIO_LEVELS = 8
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  prq_req_if.sink    in_chan,
  prq_rsp_if.source  out_chan
);

  localparam int PW = (PROC_COUNT  > 1) ? $clog2(PROC_COUNT)  : 1;
  localparam int LW = (PRIO_LEVELS > 1) ? $clog2(PRIO_LEVELS) : 1;

  // Queue state.
  logic [PW-1:0]          head_r   [PRIO_LEVELS];
  logic [PW-1:0]          tail_r   [PRIO_LEVELS];
  logic [PW-1:0]          link_r   [PROC_COUNT];
  logic [PRIO_LEVELS-1:0] nonempty_r;
  logic [PROC_COUNT-1:0]  queued_r;

  // Input register.
  logic                          req_valid_r;
  logic [prq_pkg::FUNC_W-1:0]    func_r;
  logic [prq_pkg::PROC_W-1:0]    pid_r;
  logic [prq_pkg::PRIO_W-1:0]    lvl_r;
  logic                          blk_r;

  // Output register.
  logic                          rsp_valid_r;
  logic [prq_pkg::STATUS_W-1:0]  status_r;
  logic [prq_pkg::PROC_W-1:0]    chosen_proc_r;
  logic [prq_pkg::PRIO_W-1:0]    chosen_prio_r;

  // Handshake: the request register advances when the output register frees.
  logic advance;
  logic fire;
  assign advance       = !rsp_valid_r || out_chan.ready;
  assign fire          = req_valid_r && advance;
  assign in_chan.ready = !req_valid_r || advance;

  // Level encoder over the non-empty flags.
  logic          any_ready;
  logic [LW-1:0] pick_lvl;
  prq_pick #(
    .LEVELS (PRIO_LEVELS),
    .LVL_W  (LW)
  ) u_pick (
    .nonempty (nonempty_r),
    .found    (any_ready),
    .level    (pick_lvl)
  );

  // Request decode and insert checks.
  logic          is_insert;
  logic          is_dequeue;
  logic          pid_ok;
  logic [PW-1:0] pid_idx;
  logic [LW-1:0] ins_lvl;
  logic          pid_busy;

  assign is_insert  = (func_r == prq_pkg::FUNC_ENQ_TAIL) || (func_r == prq_pkg::FUNC_ENQ_HEAD);
  assign is_dequeue = (func_r == prq_pkg::FUNC_DEQUEUE);
  assign pid_ok     = (32'(pid_r) < PROC_COUNT);
  assign pid_idx    = PW'(pid_r);
  assign ins_lvl    = (32'(lvl_r) >= PRIO_LEVELS) ? LW'(PRIO_LEVELS - 1) : LW'(lvl_r);
  assign pid_busy   = pid_ok && queued_r[pid_idx];

  // Dequeue candidate.
  logic [PW-1:0] deq_proc;
  logic          deq_last;
  assign deq_proc = head_r[pick_lvl];
  assign deq_last = (deq_proc == tail_r[pick_lvl]);

  // Outcome of the current request.
  logic                          do_insert;
  logic                          do_dequeue;
  logic [prq_pkg::STATUS_W-1:0]  status_nxt;
  logic [prq_pkg::PROC_W-1:0]    chosen_proc_nxt;
  logic [prq_pkg::PRIO_W-1:0]    chosen_prio_nxt;

  always_comb begin
    do_insert       = 1'b0;
    do_dequeue      = 1'b0;
    status_nxt      = prq_pkg::ST_OK;
    chosen_proc_nxt = '0;
    chosen_prio_nxt = '0;
    if (is_insert) begin
      if (blk_r || !pid_ok) begin
        status_nxt = prq_pkg::ST_BLOCKED;
      end else if (pid_busy) begin
        status_nxt = prq_pkg::ST_QUEUED;
      end else begin
        do_insert = 1'b1;
      end
    end else if (is_dequeue) begin
      if (any_ready) begin
        do_dequeue      = 1'b1;
        chosen_proc_nxt = prq_pkg::PROC_W'(deq_proc);
        chosen_prio_nxt = prq_pkg::PRIO_W'(pick_lvl);
      end else begin
        status_nxt = prq_pkg::ST_EMPTY;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      rsp_valid_r <= 1'b0;
      nonempty_r  <= '0;
      queued_r    <= '0;
    end else begin
      if (in_chan.ready) begin
        req_valid_r <= in_chan.valid;
      end
      if (advance) begin
        rsp_valid_r <= req_valid_r;
      end
      if (fire && do_insert) begin
        nonempty_r[ins_lvl] <= 1'b1;
        queued_r[pid_idx]   <= 1'b1;
      end
      if (fire && do_dequeue) begin
        queued_r[deq_proc] <= 1'b0;
        if (deq_last) begin
          nonempty_r[pick_lvl] <= 1'b0;
        end
      end
    end
  end

  // Payload registers and list tables.
  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      func_r <= in_chan.func;
      pid_r  <= in_chan.proc_id;
      lvl_r  <= in_chan.priority_req;
      blk_r  <= in_chan.blocked;
    end
    if (fire) begin
      status_r      <= status_nxt;
      chosen_proc_r <= chosen_proc_nxt;
      chosen_prio_r <= chosen_prio_nxt;
    end
    if (fire && do_insert) begin
      if (!nonempty_r[ins_lvl]) begin
        head_r[ins_lvl] <= pid_idx;
        tail_r[ins_lvl] <= pid_idx;
      end else if (func_r == prq_pkg::FUNC_ENQ_TAIL) begin
        link_r[tail_r[ins_lvl]] <= pid_idx;
        tail_r[ins_lvl]         <= pid_idx;
      end else begin
        link_r[pid_idx] <= head_r[ins_lvl];
        head_r[ins_lvl] <= pid_idx;
      end
    end
    if (fire && do_dequeue && !deq_last) begin
      head_r[pick_lvl] <= link_r[deq_proc];
    end
  end

  // Result channel.
  assign out_chan.valid           = rsp_valid_r;
  assign out_chan.status          = status_r;
  assign out_chan.chosen_proc     = chosen_proc_r;
  assign out_chan.chosen_priority = chosen_prio_r;

endmodule

`default_nettype wire

FILE: rtl/core/prq_pick.sv
// Lowest-numbered non-empty level finder for the run-queue scheduler.
// Pure combinational priority encoder; no package dependencies.
`default_nettype none

module prq_pick #(
  parameter int LEVELS = 8,
  parameter int LVL_W  = 3
) (
  input  wire logic [LEVELS-1:0] nonempty,
  output logic                   found,
  output logic [LVL_W-1:0]       level
);

  // Scan from the lowest-priority level down so that the smallest index wins.
  always_comb begin
    found = 1'b0;
    level = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        found = 1'b1;
        level = LVL_W'(i);
      end
    end
  end

endmodule

`default_nettype wire
